FILE: hw/rtl/mcc_pkg.sv
package mcc_pkg;

  localparam int FRAC_BITS = 28;

  // coordinate of a sub-point: 32-bit corner plus offset below 2^30
  localparam int CW  = 33;
  // z components before the bound check
  localparam int ZW  = FRAC_BITS + 8;
  // |z| after the bound check (at most 4.0)
  localparam int MW  = FRAC_BITS + 3;
  // squared terms (sr, si), at most 16.0
  localparam int SW  = FRAC_BITS + 5;
  // magnitude of the cross term
  localparam int PMW = FRAC_BITS + 6;
  localparam int PW  = PMW + 1;

  localparam logic signed [ZW-1:0] LIM_POS = ZW'(1) << (FRAC_BITS + 2);
  localparam logic signed [ZW-1:0] LIM_NEG = -LIM_POS;
  localparam logic [SW:0]          ESC_LIM = (SW + 1)'(1) << (FRAC_BITS + 4);

  localparam int QDEPTH = 2;

  typedef enum logic [1:0] {
    REG_STEP_X   = 2'd0,
    REG_STEP_Y   = 2'd1,
    REG_MARCHING = 2'd2,
    REG_MAX_ITER = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] cr;
    logic signed [31:0] ci;
    logic [29:0]        hx;
    logic [29:0]        hy;
    logic               marching;
    logic [15:0]        max_iter;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_INIT,
    BK_FORM,
    BK_MUL,
    BK_DONE
  } bk_state_t;

endpackage

FILE: hw/rtl/mcc_queue.sv
module mcc_queue
  import mcc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic valid,
  output job_t pop_job
);

  job_t                      mem_r [QDEPTH];
  logic [$clog2(QDEPTH)-1:0] wptr_r;
  logic [$clog2(QDEPTH)-1:0] rptr_r;
  logic [$clog2(QDEPTH):0]   cnt_r;

  assign full    = (cnt_r == ($clog2(QDEPTH) + 1)'(QDEPTH));
  assign valid   = (cnt_r != '0);
  assign pop_job = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/mcc_front.sv
module mcc_front
  import mcc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_point_real,
  input  logic signed [31:0] in_point_imag,
  input  logic               q_full,
  output logic               push,
  output job_t               push_job
);

  logic [30:0] step_x_r;
  logic [30:0] step_y_r;
  logic        march_r;
  logic [15:0] max_iter_r;
  reg_idx_t    idx;
  logic        wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_x_r   <= '0;
      step_y_r   <= '0;
      march_r    <= 1'b0;
      max_iter_r <= 16'd200;
    end else if (wr_en) begin
      case (idx)
        REG_STEP_X:   step_x_r   <= pwdata[30:0];
        REG_STEP_Y:   step_y_r   <= pwdata[30:0];
        REG_MARCHING: march_r    <= pwdata[0];
        REG_MAX_ITER: max_iter_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_STEP_X:   prdata = {1'b0, step_x_r};
      REG_STEP_Y:   prdata = {1'b0, step_y_r};
      REG_MARCHING: prdata = {31'd0, march_r};
      REG_MAX_ITER: prdata = {16'd0, max_iter_r};
      default:      prdata = '0;
    endcase
  end

  // plain mode: zero offsets, one sub-point
  assign busy = q_full;
  assign push = start && !busy;

  always_comb begin
    push_job.cr       = in_point_real;
    push_job.ci       = in_point_imag;
    push_job.hx       = march_r ? step_x_r[30:1] : 30'd0;
    push_job.hy       = march_r ? step_y_r[30:1] : 30'd0;
    push_job.marching = march_r;
    push_job.max_iter = max_iter_r;
  end

endmodule

FILE: hw/rtl/mcc_back.sv
module mcc_back
  import mcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  job_t       q_job,
  output logic       pop,
  output logic       out_strobe,
  output logic [3:0] out_cell_code
);

  bk_state_t state_r;
  bk_state_t state_nxt;

  job_t                  job_r;
  logic [1:0]            sub_r;
  logic [3:0]            code_r;
  logic [15:0]           n_r;
  logic signed [CW-1:0]  cr_r;
  logic signed [CW-1:0]  ci_r;
  logic [SW-1:0]         sr_r;
  logic [SW-1:0]         si_r;
  logic signed [PW-1:0]  p_r;
  logic [MW-1:0]         azr_r;
  logic [MW-1:0]         azi_r;
  logic                  pneg_r;

  logic [29:0]           hx_sel;
  logic [29:0]           hy_sel;
  logic signed [ZW-1:0]  zr;
  logic signed [ZW-1:0]  zi;
  logic signed [ZW-1:0]  zr_abs;
  logic signed [ZW-1:0]  zi_abs;
  logic [SW:0]           mag;
  logic                  esc_hit;
  logic                  iter_done;
  logic                  bound_hit;
  logic                  pt_done;
  logic                  pt_inside;
  logic                  last_pt;
  logic [2*MW-1:0]       prod_rr;
  logic [2*MW-1:0]       prod_ii;
  logic [2*MW-1:0]       prod_ri;
  logic [PMW-1:0]        pmag;

  assign hx_sel = sub_r[0] ? job_r.hx : 30'd0;
  assign hy_sel = sub_r[1] ? job_r.hy : 30'd0;

  assign zr = $signed({{(ZW-SW){1'b0}}, sr_r}) - $signed({{(ZW-SW){1'b0}}, si_r})
            + {{(ZW-CW){cr_r[CW-1]}}, cr_r};
  assign zi = {{(ZW-PW){p_r[PW-1]}}, p_r} + {{(ZW-CW){ci_r[CW-1]}}, ci_r};

  assign zr_abs = zr[ZW-1] ? -zr : zr;
  assign zi_abs = zi[ZW-1] ? -zi : zi;

  assign mag       = {1'b0, sr_r} + {1'b0, si_r};
  assign esc_hit   = (mag > ESC_LIM);
  assign iter_done = (n_r == job_r.max_iter);
  assign bound_hit = (zr > LIM_POS) || (zr < LIM_NEG) || (zi > LIM_POS) || (zi < LIM_NEG);
  assign pt_done   = esc_hit || iter_done || bound_hit;
  assign pt_inside = !esc_hit && iter_done;
  assign last_pt   = job_r.marching ? (sub_r == 2'd3) : 1'b1;

  assign prod_rr = {{MW{1'b0}}, azr_r} * {{MW{1'b0}}, azr_r};
  assign prod_ii = {{MW{1'b0}}, azi_r} * {{MW{1'b0}}, azi_r};
  assign prod_ri = {{MW{1'b0}}, azr_r} * {{MW{1'b0}}, azi_r};
  assign pmag    = prod_ri[FRAC_BITS-1+PMW-1:FRAC_BITS-1];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: if (q_valid) state_nxt = BK_INIT;
      BK_INIT: state_nxt = BK_FORM;
      BK_FORM: begin
        if (pt_done) begin
          state_nxt = last_pt ? BK_DONE : BK_INIT;
        end else begin
          state_nxt = BK_MUL;
        end
      end
      BK_MUL:  state_nxt = BK_FORM;
      BK_DONE: state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pop           = 1'b0;
    out_strobe    = 1'b0;
    out_cell_code = code_r;
    case (state_r)
      BK_IDLE: pop        = q_valid;
      BK_DONE: out_strobe = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        job_r  <= q_job;
        sub_r  <= 2'd0;
        code_r <= 4'd0;
      end
      BK_INIT: begin
        cr_r <= {job_r.cr[31], job_r.cr} + {3'b000, hx_sel};
        ci_r <= {job_r.ci[31], job_r.ci} + {3'b000, hy_sel};
        sr_r <= '0;
        si_r <= '0;
        p_r  <= '0;
        n_r  <= '0;
      end
      BK_FORM: begin
        if (pt_done) begin
          if (pt_inside) begin
            code_r[sub_r] <= 1'b1;
          end
          sub_r <= sub_r + 2'd1;
        end else begin
          azr_r  <= zr_abs[MW-1:0];
          azi_r  <= zi_abs[MW-1:0];
          pneg_r <= zr[ZW-1] ^ zi[ZW-1];
          n_r    <= n_r + 16'd1;
        end
      end
      BK_MUL: begin
        sr_r <= prod_rr[FRAC_BITS+SW-1:FRAC_BITS];
        si_r <= prod_ii[FRAC_BITS+SW-1:FRAC_BITS];
        p_r  <= pneg_r ? -$signed({1'b0, pmag}) : $signed({1'b0, pmag});
      end
      default: ;
    endcase
  end

endmodule

FILE: hw/rtl/mandelbrot_cell_classifier_top.sv
// Mandelbrot cell classifier. A transaction is taken when start is high and
// busy is low; a two-entry job queue sits between the input side and the
// iteration engine, so up to two cells can be taken while one is in flight.
// Each cell gives exactly one out_cell_code, shown for a single cycle with
// out_strobe; the receiver cannot stall and must take it in that cycle.
// The engine runs each complex iteration as a BK_FORM state (form z and bound
// check) followed by a BK_MUL state (the two squarings and the cross product).
// A cell is worked one test point after another (one point in plain mode, four
// in marching mode); a point stops when it escapes or reaches the limit,
// which is 200 by default and at most 65535.
// Registers (APB, pready always high): 0x0 step_x, 0x4 step_y,
// 0x8 marching_mode, 0xC max_iterations (reset 200). Change them only while
// no transaction is outstanding.
module mandelbrot_cell_classifier_top
  import mcc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_point_real,
  input  logic signed [31:0] in_point_imag,
  output logic               out_strobe,
  output logic [3:0]         out_cell_code
);

  logic q_full;
  logic q_valid;
  logic push;
  logic pop;
  job_t push_job;
  job_t pop_job;

  mcc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .start         (start),
    .busy          (busy),
    .in_point_real (in_point_real),
    .in_point_imag (in_point_imag),
    .q_full        (q_full),
    .push          (push),
    .push_job      (push_job)
  );

  mcc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .valid    (q_valid),
    .pop_job  (pop_job)
  );

  mcc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_job         (pop_job),
    .pop           (pop),
    .out_strobe    (out_strobe),
    .out_cell_code (out_cell_code)
  );

endmodule

FILE: dv/tb_mandelbrot_cell_classifier_top.sv
module tb_mandelbrot_cell_classifier_top
  import mcc_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [31:0] Q_MIN   = 32'sh8000_0000;
  localparam logic signed [31:0] Q_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_ONE   = 32'sh1000_0000;
  localparam logic signed [31:0] Q_HALF  = 32'sh0800_0000;
  localparam logic signed [31:0] Q_QTR   = 32'sh0400_0000;
  localparam logic signed [31:0] Q_M_ONE = 32'shF000_0000;
  localparam logic signed [31:0] Q_M_TWO = 32'shE000_0000;
  localparam logic signed [31:0] Q_1P9   = 32'sh1E66_6666;
  localparam logic signed [31:0] Q_0P3   = 32'sh04CC_CCCD;

  logic               clk;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               start;
  logic               busy;
  logic signed [31:0] in_point_real;
  logic signed [31:0] in_point_imag;
  logic               out_strobe;
  logic [3:0]         out_cell_code;

  // shadow copy of the register file
  logic [30:0] cfg_step_x;
  logic [30:0] cfg_step_y;
  logic        cfg_marching;
  logic [15:0] cfg_max_iter;

  logic [3:0] pending_codes[$];
  logic [3:0] want_code;
  int         fail_count;
  bit         no_gaps;

  mandelbrot_cell_classifier_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .start         (start),
    .busy          (busy),
    .in_point_real (in_point_real),
    .in_point_imag (in_point_imag),
    .out_strobe    (out_strobe),
    .out_cell_code (out_cell_code)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // |a|*|b| >> sh, sign applied afterwards (truncates toward zero)
  function automatic longint fx_mul_trunc(input longint a, input longint b,
                                          input int unsigned sh);
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [127:0] mag;
    bit           neg;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? -a : a;
    ub  = (b < 0) ? -b : b;
    mag = ua * ub;
    mag = mag >> sh;
    return neg ? -$signed(mag[63:0]) : $signed(mag[63:0]);
  endfunction

  function automatic bit point_in_set(input longint cr, input longint ci);
    longint lim;
    longint esc;
    longint sq_re;
    longint sq_im;
    longint cross_term;
    longint zr;
    longint zi;
    lim        = longint'(4) << FRAC_BITS;
    esc        = longint'(16) << FRAC_BITS;
    sq_re      = 0;
    sq_im      = 0;
    cross_term = 0;
    for (int n = 0; n < cfg_max_iter; n++) begin
      zr = sq_re - sq_im + cr;
      zi = cross_term + ci;
      if (zr > lim || zr < -lim || zi > lim || zi < -lim)
        return 1'b0;
      sq_re = fx_mul_trunc(zr, zr, FRAC_BITS);
      sq_im = fx_mul_trunc(zi, zi, FRAC_BITS);
      if (sq_re + sq_im > esc)
        return 1'b0;
      cross_term = fx_mul_trunc(zr, zi, FRAC_BITS - 1);
    end
    return 1'b1;
  endfunction

  function automatic logic [3:0] classify_cell(input logic signed [31:0] re,
                                               input logic signed [31:0] im);
    longint     cr;
    longint     ci;
    longint     hx;
    longint     hy;
    logic [3:0] code;
    cr   = re;
    ci   = im;
    hx   = cfg_step_x >> 1;
    hy   = cfg_step_y >> 1;
    code = 4'd0;
    if (cfg_marching) begin
      for (int y = 0; y < 2; y++)
        for (int x = 0; x < 2; x++)
          if (point_in_set(cr + x * hx, ci + y * hy))
            code[y * 2 + x] = 1'b1;
    end else begin
      code[0] = point_in_set(cr, ci);
    end
    return code;
  endfunction

  // result checker; results cannot be stalled, so every strobe is a transaction
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_codes.size() == 0) begin
        $error("cell_code: unexpected result, expected none, got %h", out_cell_code);
        fail_count++;
      end else begin
        want_code = pending_codes.pop_front();
        if (out_cell_code !== want_code) begin
          $error("cell_code: expected %h, got %h", want_code, out_cell_code);
          fail_count++;
        end
      end
    end
  end

  task automatic apb_xfer(input logic wr, input reg_idx_t idx, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(input reg_idx_t idx);
    logic [31:0] got;
    logic [31:0] want;
    case (idx)
      REG_STEP_X:   want = {1'b0, cfg_step_x};
      REG_STEP_Y:   want = {1'b0, cfg_step_y};
      REG_MARCHING: want = {31'd0, cfg_marching};
      REG_MAX_ITER: want = {16'd0, cfg_max_iter};
      default:      want = '0;
    endcase
    apb_xfer(1'b0, idx, 32'd0, got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", idx.name(), want, got);
      fail_count++;
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    logic [31:0] unused;
    wait_idle();
    apb_xfer(1'b1, idx, value, unused);
    case (idx)
      REG_STEP_X:   cfg_step_x   = value[30:0];
      REG_STEP_Y:   cfg_step_y   = value[30:0];
      REG_MARCHING: cfg_marching = value[0];
      REG_MAX_ITER: cfg_max_iter = value[15:0];
      default: ;
    endcase
    check_reg(idx);
  endtask

  // start stays high between back-to-back transactions
  task automatic send_cell(input logic signed [31:0] re, input logic signed [31:0] im);
    int unsigned gap;
    gap = 0;
    if (!no_gaps && $urandom_range(99) < 24)
      gap = $urandom_range(1, 30);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_point_real <= re;
    in_point_imag <= im;
    do @(posedge clk); while (busy);
    pending_codes.push_back(classify_cell(re, im));
  endtask

  function automatic logic signed [31:0] rand_coord(input bit re_axis);
    int          pick;
    logic [31:0] raw;
    pick = $urandom_range(99);
    raw  = $urandom;
    if (pick < 60) begin
      // window around the set: re in [-2.25, 0.75], im in [-1.5, 1.5]
      raw = $urandom_range(0, 805306368);
      return re_axis ? $signed(raw) - 603979776 : $signed(raw) - 402653184;
    end
    if (pick < 85)
      return $signed(raw);
    case ($urandom_range(7))
      0: return Q_MIN;
      1: return Q_MAX;
      2: return 32'sd0;
      3: return Q_M_TWO;
      4: return 32'sh4000_0000;
      5: return -32'sh4000_0000;
      6: return 32'sd1;
      default: return -32'sd1;
    endcase
  endfunction

  function automatic logic [31:0] rand_step();
    int pick;
    pick = $urandom_range(99);
    if (pick < 50)
      return $urandom_range(0, 1 << 26);
    if (pick < 80)
      return $urandom_range(0, 1 << 29);
    return $urandom;
  endfunction

  task automatic test_reset_defaults();
    for (int i = 0; i < 4; i++)
      check_reg(reg_idx_t'(i));
  endtask

  task automatic test_plain_cells();
    send_cell(32'sd0, 32'sd0);
    send_cell(Q_MIN, Q_MIN);
    send_cell(Q_MAX, Q_MAX);
    send_cell(Q_MIN, Q_MAX);
    send_cell(Q_M_TWO, 32'sd0);
    send_cell(Q_1P9, Q_1P9);
    send_cell(Q_QTR, 32'sd0);
    send_cell(Q_0P3, 32'sd0);
  endtask

  task automatic test_iteration_limits();
    write_reg(REG_MAX_ITER, 32'd0);
    send_cell(Q_MAX, Q_MAX);
    send_cell(32'sd0, 32'sd0);
    write_reg(REG_STEP_X, Q_ONE);
    write_reg(REG_STEP_Y, Q_ONE);
    write_reg(REG_MARCHING, 32'd1);
    send_cell(Q_MIN, Q_MIN);
    write_reg(REG_MAX_ITER, 32'd1);
    send_cell(Q_1P9, 32'sd0);
    send_cell(Q_MAX, 32'sd0);
    write_reg(REG_MARCHING, 32'd0);
    write_reg(REG_MAX_ITER, 32'h0000_FFFF);
    send_cell(32'sd0, 32'sd0);
    send_cell(Q_ONE, Q_ONE);
    write_reg(REG_MAX_ITER, 32'd200);
  endtask

  task automatic test_marching_cells();
    write_reg(REG_MARCHING, 32'd1);
    write_reg(REG_STEP_X, 32'hFFFF_FFFF);
    write_reg(REG_STEP_Y, 32'h7FFF_FFFF);
    send_cell(Q_MAX, Q_MAX);
    send_cell(Q_MIN, Q_MIN);
    send_cell(Q_M_TWO, Q_M_TWO);
    write_reg(REG_STEP_X, Q_ONE);
    write_reg(REG_STEP_Y, Q_ONE);
    send_cell(32'sd0, Q_HALF);
    send_cell(Q_M_ONE, 32'sd0);
    // odd steps: offsets of one and zero LSB
    write_reg(REG_STEP_X, 32'd3);
    write_reg(REG_STEP_Y, 32'd1);
    send_cell(32'sd0, 32'sd0);
    send_cell(Q_QTR, 32'sd0);
    write_reg(REG_STEP_X, 32'd0);
    write_reg(REG_STEP_Y, 32'd0);
    send_cell(Q_0P3, 32'sd0);
  endtask

  task automatic test_random_cells();
    logic [31:0] limit;
    for (int ph = 0; ph < 15; ph++) begin
      no_gaps = (ph >= 5 && ph < 8);
      limit   = (ph == 0) ? 32'd0 : $urandom_range(1, 96);
      write_reg(REG_STEP_X, rand_step());
      write_reg(REG_STEP_Y, rand_step());
      write_reg(REG_MARCHING, $urandom);
      write_reg(REG_MAX_ITER, ($urandom & 32'hFFFF_0000) | limit);
      for (int i = 0; i < 48; i++)
        send_cell(rand_coord(1'b1), rand_coord(1'b0));
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_n         <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    start         <= 1'b0;
    in_point_real <= '0;
    in_point_imag <= '0;
    cfg_step_x    = '0;
    cfg_step_y    = '0;
    cfg_marching  = 1'b0;
    cfg_max_iter  = 16'd200;
    fail_count    = 0;
    no_gaps       = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_plain_cells();
    test_iteration_limits();
    test_marching_cells();
    test_random_cells();

    wait_idle();
    repeat (64) @(posedge clk);
    if (fail_count == 0)
      $display("tb_mandelbrot_cell_classifier_top: done, clean");
    else
      $display("tb_mandelbrot_cell_classifier_top: done, errors");
    $finish;
  end

  initial begin
    #30_000_000;
    $display("tb_mandelbrot_cell_classifier_top: done, errors");
    $finish;
  end

endmodule
